// ===== hdl/gmaze_pkg.sv =====
package gmaze_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 32;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 5;
    localparam int CELL_W     = ROW_W + COL_W;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int DEPTH_W    = CELL_W + 1;
    localparam int SIZE_W     = 6;
    localparam int PADDR_W    = 4;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SROW   = 2'd2;
    localparam logic [1:0] REG_SCOL   = 2'd3;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_START,
        S_IDLE,
        S_POP,
        S_POPWAIT,
        S_PRB,
        S_CHK,
        S_EVAL,
        S_WRCUR,
        S_WRNBR,
        S_QRD,
        S_QOUT,
        S_DONE
    } state_t;

    // clamp a size register into 1..max
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] mx);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > mx)
            r = mx;
        else
            r = v;
        return r;
    endfunction

    // pick modulo n for n in 1..4
    function automatic logic [1:0] pick_mod(input logic [7:0] p, input logic [2:0] n);
        logic [3:0] s;
        logic [1:0] k;
        s = 4'(p[1:0]) + 4'(p[3:2]) + 4'(p[5:4]) + 4'(p[7:6]);
        k = 2'd0;
        unique case (n)
            3'd2: k = {1'b0, p[0]};
            3'd3:
            begin
                unique case (s)
                    4'd1, 4'd4, 4'd7, 4'd10: k = 2'd1;
                    4'd2, 4'd5, 4'd8, 4'd11: k = 2'd2;
                    default: k = 2'd0;
                endcase
            end
            3'd4: k = p[1:0];
            default: k = 2'd0;
        endcase
        return k;
    endfunction

    // k-th set bit of mask, north first
    function automatic logic [1:0] kth_dir(input logic [3:0] m, input logic [1:0] k);
        logic [2:0] cnt;
        logic [1:0] d;
        cnt = '0;
        d = DIR_N;
        for (int i = 0; i < 4; i++)
        begin
            if (m[i])
            begin
                if (cnt == {1'b0, k})
                    d = 2'(i);
                cnt = cnt + 3'd1;
            end
        end
        return d;
    endfunction

endpackage

// ===== hdl/grid_maze_dfs_carver_top.sv =====
// Maze carver by randomized depth-first search over a 32 by 32 cell store.
// After reset the block sweeps its cell memory before it takes any item; a
// start item repeats that sweep. A step probes the four neighbors of the stack
// top through the cell memory read port, one at a time, and carves by writing
// the current cell and the neighbor; every dead end met on the way is popped.
// A read looks up one cell. One item is worked on at a time; the result
// register lets the next item enter while a result waits. Configure only
// between items.
module grid_maze_dfs_carver_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gmaze_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     opcode,
    input  logic [7:0]                     random_pick,
    input  logic [gmaze_pkg::ROW_W-1:0]    query_row,
    input  logic [gmaze_pkg::COL_W-1:0]    query_col,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [gmaze_pkg::ROW_W-1:0]    carved_row,
    output logic [gmaze_pkg::COL_W-1:0]    carved_col,
    output logic [1:0]                     carved_dir,
    output logic                           carved,
    output logic                           finished,
    output logic [3:0]                     wall_bits,
    output logic                           bad_query
);
    import gmaze_pkg::*;

    logic [SIZE_W-1:0] grid_width_reg, grid_height_reg;
    logic [ROW_W-1:0]  start_row_reg;
    logic [COL_W-1:0]  start_col_reg;

    state_t state_reg, state_next;

    logic [1:0]         op_reg;
    logic [7:0]         pick_reg;
    logic [ROW_W-1:0]   qrow_reg;
    logic [COL_W-1:0]   qcol_reg;
    logic [CELL_W-1:0]  clr_reg, clr_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [CELL_W-1:0]  cur_reg, cur_next;
    logic [1:0]         dir_reg, dir_next;
    logic [3:0]         mask_reg, mask_next;
    logic               inside_reg, inside_next;

    logic [ROW_W-1:0]   res_row_reg, res_row_next;
    logic [COL_W-1:0]   res_col_reg, res_col_next;
    logic [1:0]         res_dir_reg, res_dir_next;
    logic               res_carved_reg, res_carved_next;
    logic [3:0]         res_walls_reg, res_walls_next;
    logic               res_bad_reg, res_bad_next;

    logic               out_valid_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [1:0]         out_dir_reg;
    logic               out_carved_reg;
    logic               out_fin_reg;
    logic [3:0]         out_walls_reg;
    logic               out_bad_reg;

    logic [4:0]         cell_mem [CELLS];
    logic [4:0]         cell_rdata;
    logic [CELL_W-1:0]  cell_raddr, cell_waddr;
    logic [4:0]         cell_wdata;
    logic               cell_we;

    logic [CELL_W-1:0]  stack_mem [CELLS];
    logic [CELL_W-1:0]  stack_rdata;
    logic [CELL_W-1:0]  stack_raddr;
    logic               stack_we;

    logic [SIZE_W-1:0]  rows_used, cols_used;
    logic [ROW_W-1:0]   cur_r, start_r;
    logic [COL_W-1:0]   cur_c, start_c;
    logic [SIZE_W-1:0]  r6, c6;
    logic               nbr_in;
    logic [ROW_W-1:0]   nbr_r;
    logic [COL_W-1:0]   nbr_c;
    logic [CELL_W-1:0]  nbr_addr;
    logic [2:0]         nbr_cnt;
    logic [1:0]         chosen;
    logic               in_fire, out_slot, q_inside;
    logic               apb_wr;

    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_slot  = !out_valid_reg || out_ready;

    assign rows_used = clamp_size(grid_height_reg, SIZE_W'(MAX_HEIGHT));
    assign cols_used = clamp_size(grid_width_reg, SIZE_W'(MAX_WIDTH));

    assign start_r = ({1'b0, start_row_reg} > rows_used - SIZE_W'(1))
                     ? ROW_W'(rows_used - SIZE_W'(1)) : start_row_reg;
    assign start_c = ({1'b0, start_col_reg} > cols_used - SIZE_W'(1))
                     ? COL_W'(cols_used - SIZE_W'(1)) : start_col_reg;

    assign cur_r = cur_reg[CELL_W-1:COL_W];
    assign cur_c = cur_reg[COL_W-1:0];
    assign r6    = {1'b0, cur_r};
    assign c6    = {1'b0, cur_c};

    assign q_inside = ({1'b0, qrow_reg} < rows_used) && ({1'b0, qcol_reg} < cols_used);

    always_comb
    begin
        nbr_in = 1'b0;
        nbr_r  = cur_r;
        nbr_c  = cur_c;
        unique case (dir_reg)
            DIR_N:
            begin
                nbr_r  = cur_r - ROW_W'(1);
                nbr_in = (cur_r != '0) && (r6 - SIZE_W'(1) < rows_used) && (c6 < cols_used);
            end
            DIR_E:
            begin
                nbr_c  = cur_c + COL_W'(1);
                nbr_in = (c6 + SIZE_W'(1) < cols_used) && (r6 < rows_used);
            end
            DIR_S:
            begin
                nbr_r  = cur_r + ROW_W'(1);
                nbr_in = (r6 + SIZE_W'(1) < rows_used) && (c6 < cols_used);
            end
            DIR_W:
            begin
                nbr_c  = cur_c - COL_W'(1);
                nbr_in = (cur_c != '0) && (c6 - SIZE_W'(1) < cols_used) && (r6 < rows_used);
            end
            default:
            begin
                nbr_in = 1'b0;
            end
        endcase
    end

    assign nbr_addr = {nbr_r, nbr_c};
    assign nbr_cnt  = 3'($countones(mask_reg));
    assign chosen   = kth_dir(mask_reg, pick_mod(pick_reg, nbr_cnt));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CELL_W'(CELLS - 1))
                    state_next = (op_reg == OP_START) ? S_START : S_IDLE;
            end
            S_START:   state_next = S_DONE;
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (opcode)
                        OP_START: state_next = S_CLEAR;
                        OP_STEP:  state_next = S_POP;
                        OP_READ:  state_next = S_QRD;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_POP:     state_next = (depth_reg == '0) ? S_DONE : S_POPWAIT;
            S_POPWAIT: state_next = S_PRB;
            S_PRB:     state_next = S_CHK;
            S_CHK:     state_next = (dir_reg == DIR_W) ? S_EVAL : S_PRB;
            S_EVAL:    state_next = (mask_reg == '0) ? S_POP : S_WRCUR;
            S_WRCUR:   state_next = S_WRNBR;
            S_WRNBR:   state_next = S_DONE;
            S_QRD:     state_next = S_QOUT;
            S_QOUT:    state_next = S_DONE;
            S_DONE:
            begin
                if (out_slot)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        clr_next        = clr_reg;
        depth_next      = depth_reg;
        cur_next        = cur_reg;
        dir_next        = dir_reg;
        mask_next       = mask_reg;
        inside_next     = inside_reg;
        res_row_next    = res_row_reg;
        res_col_next    = res_col_reg;
        res_dir_next    = res_dir_reg;
        res_carved_next = res_carved_reg;
        res_walls_next  = res_walls_reg;
        res_bad_next    = res_bad_reg;
        cell_raddr      = nbr_addr;
        cell_waddr      = clr_reg;
        cell_wdata      = 5'b01111;
        cell_we         = 1'b0;
        stack_raddr     = CELL_W'(depth_reg - DEPTH_W'(1));
        stack_we        = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cell_we  = 1'b1;
                clr_next = clr_reg + CELL_W'(1);
                depth_next = '0;
            end
            S_START:
            begin
                cell_waddr = {start_r, start_c};
                cell_wdata = 5'b11111;
                cell_we    = 1'b1;
                cur_next   = {start_r, start_c};
                stack_we   = 1'b1;
                depth_next = DEPTH_W'(1);
            end
            S_IDLE:
            begin
                res_row_next    = '0;
                res_col_next    = '0;
                res_dir_next    = '0;
                res_carved_next = 1'b0;
                res_walls_next  = '0;
                res_bad_next    = 1'b0;
                clr_next        = '0;
            end
            S_POPWAIT:
            begin
                cur_next  = stack_rdata;
                dir_next  = DIR_N;
                mask_next = '0;
            end
            S_PRB:
            begin
                inside_next = nbr_in;
            end
            S_CHK:
            begin
                if (inside_reg && !cell_rdata[4])
                    mask_next = mask_reg | (4'd1 << dir_reg);
                dir_next = dir_reg + 2'd1;
            end
            S_EVAL:
            begin
                cell_raddr = cur_reg;
                if (mask_reg == '0)
                    depth_next = depth_reg - DEPTH_W'(1);
                else
                    dir_next = chosen;
            end
            S_WRCUR:
            begin
                cell_waddr = cur_reg;
                cell_wdata = cell_rdata & ~(5'd1 << dir_reg);
                cell_we    = 1'b1;
            end
            S_WRNBR:
            begin
                cell_waddr = nbr_addr;
                cell_wdata = (cell_rdata & ~(5'd1 << (dir_reg + 2'd2))) | 5'b10000;
                cell_we    = 1'b1;
                if (depth_reg < DEPTH_W'(CELLS))
                begin
                    stack_we   = 1'b1;
                    depth_next = depth_reg + DEPTH_W'(1);
                end
                res_row_next    = cur_r;
                res_col_next    = cur_c;
                res_dir_next    = dir_reg;
                res_carved_next = 1'b1;
            end
            S_QRD:
            begin
                cell_raddr = {qrow_reg, qcol_reg};
            end
            S_QOUT:
            begin
                res_bad_next   = !q_inside;
                res_walls_next = q_inside ? cell_rdata[3:0] : 4'd0;
            end
            default:
            begin
                cell_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[cell_waddr] <= cell_wdata;
        cell_rdata <= cell_mem[cell_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[depth_reg[CELL_W-1:0]] <= (state_reg == S_START) ? cur_next : nbr_addr;
        stack_rdata <= stack_mem[stack_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= SIZE_W'(MAX_WIDTH);
            grid_height_reg <= SIZE_W'(MAX_HEIGHT);
            start_row_reg   <= '0;
            start_col_reg   <= '0;
        end
        else if (apb_wr)
        begin
            unique case (paddr[3:2])
                REG_WIDTH:  grid_width_reg  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: grid_height_reg <= pwdata[SIZE_W-1:0];
                REG_SROW:   start_row_reg   <= pwdata[ROW_W-1:0];
                REG_SCOL:   start_col_reg   <= pwdata[COL_W-1:0];
                default:    grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(grid_width_reg);
            REG_HEIGHT: prdata = 32'(grid_height_reg);
            REG_SROW:   prdata = 32'(start_row_reg);
            REG_SCOL:   prdata = 32'(start_col_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            op_reg        <= '1;
            clr_reg       <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            depth_reg <= depth_next;
            if (in_fire)
                op_reg <= opcode;
            if (state_reg == S_DONE && out_slot)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg         <= cur_next;
        dir_reg         <= dir_next;
        mask_reg        <= mask_next;
        inside_reg      <= inside_next;
        res_row_reg     <= res_row_next;
        res_col_reg     <= res_col_next;
        res_dir_reg     <= res_dir_next;
        res_carved_reg  <= res_carved_next;
        res_walls_reg   <= res_walls_next;
        res_bad_reg     <= res_bad_next;
        if (in_fire)
        begin
            pick_reg <= random_pick;
            qrow_reg <= query_row;
            qcol_reg <= query_col;
        end
        if (state_reg == S_DONE && out_slot)
        begin
            out_row_reg    <= res_row_reg;
            out_col_reg    <= res_col_reg;
            out_dir_reg    <= res_dir_reg;
            out_carved_reg <= res_carved_reg;
            out_fin_reg    <= (depth_reg == '0);
            out_walls_reg  <= res_walls_reg;
            out_bad_reg    <= res_bad_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign carved_row = out_row_reg;
    assign carved_col = out_col_reg;
    assign carved_dir = out_dir_reg;
    assign carved     = out_carved_reg;
    assign finished   = out_fin_reg;
    assign wall_bits  = out_walls_reg;
    assign bad_query  = out_bad_reg;

endmodule

// ===== dv/grid_maze_checker.sv =====
module grid_maze_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gmaze_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          pready,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [1:0]                    opcode,
    input  logic [7:0]                    random_pick,
    input  logic [gmaze_pkg::ROW_W-1:0]   query_row,
    input  logic [gmaze_pkg::COL_W-1:0]   query_col,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [gmaze_pkg::ROW_W-1:0]   carved_row,
    input  logic [gmaze_pkg::COL_W-1:0]   carved_col,
    input  logic [1:0]                    carved_dir,
    input  logic                          carved,
    input  logic                          finished,
    input  logic [3:0]                    wall_bits,
    input  logic                          bad_query,
    output int                            fail_count,
    output int                            pending,
    output int                            carve_count,
    output int                            done_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import gmaze_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [1:0]       dir;
        logic             carved;
        logic             finished;
        logic [3:0]       walls;
        logic             bad;
    } cell_result_t;

    logic [5:0]        cols_cfg, rows_cfg;
    logic [4:0]        srow_cfg, scol_cfg;
    logic [3:0]        walls [CELLS];
    logic              seen [CELLS];
    logic [CELL_W-1:0] path [CELLS];
    int                path_depth;
    cell_result_t      expected_q [$];

    function automatic int used(input logic [5:0] v, input int mx);
        if (v == 0)
            return 1;
        if (v > mx)
            return mx;
        return v;
    endfunction

    function automatic bit on_grid(input int r, input int c);
        return r >= 0 && r < used(rows_cfg, MAX_HEIGHT) && c >= 0
            && c < used(cols_cfg, MAX_WIDTH);
    endfunction

    task automatic carve_predict(input logic [1:0] op, input logic [7:0] pick,
                                 input int qr, input int qc, output cell_result_t e);
        int r, c, nr, nc, n, d, idx, nidx;
        int dirs [4];
        int dr [4] = '{-1, 0, 1, 0};
        int dc [4] = '{0, 1, 0, -1};
        e = '0;
        if (op == OP_START)
        begin
            r = srow_cfg;
            c = scol_cfg;
            if (r > used(rows_cfg, MAX_HEIGHT) - 1)
                r = used(rows_cfg, MAX_HEIGHT) - 1;
            if (c > used(cols_cfg, MAX_WIDTH) - 1)
                c = used(cols_cfg, MAX_WIDTH) - 1;
            for (int i = 0; i < CELLS; i++)
            begin
                walls[i] = 4'hf;
                seen[i] = 1'b0;
            end
            idx = r * MAX_WIDTH + c;
            seen[idx] = 1'b1;
            path[0] = CELL_W'(idx);
            path_depth = 1;
        end
        else if (op == OP_STEP)
        begin
            while (path_depth > 0)
            begin
                idx = path[path_depth - 1];
                r = idx / MAX_WIDTH;
                c = idx % MAX_WIDTH;
                n = 0;
                for (int k = 0; k < 4; k++)
                begin
                    nr = r + dr[k];
                    nc = c + dc[k];
                    if (on_grid(nr, nc) && !seen[nr * MAX_WIDTH + nc])
                    begin
                        dirs[n] = k;
                        n++;
                    end
                end
                if (n == 0)
                begin
                    path_depth--;
                    continue;
                end
                d = dirs[pick % n];
                nidx = (r + dr[d]) * MAX_WIDTH + c + dc[d];
                walls[idx][d] = 1'b0;
                walls[nidx][(d + 2) % 4] = 1'b0;
                seen[nidx] = 1'b1;
                if (path_depth < CELLS)
                begin
                    path[path_depth] = CELL_W'(nidx);
                    path_depth++;
                end
                e.row = ROW_W'(r);
                e.col = COL_W'(c);
                e.dir = 2'(d);
                e.carved = 1'b1;
                break;
            end
        end
        else if (op == OP_READ)
        begin
            if (on_grid(qr, qc))
                e.walls = walls[qr * MAX_WIDTH + qc];
            else
                e.bad = 1'b1;
        end
        e.finished = (path_depth == 0);
    endtask

    initial
    begin
        cols_cfg = 6'd32;
        rows_cfg = 6'd32;
        srow_cfg = '0;
        scol_cfg = '0;
        for (int i = 0; i < CELLS; i++)
        begin
            walls[i] = 4'hf;
            seen[i] = 1'b0;
        end
        path_depth = 0;
        fail_count = 0;
        pending = 0;
        carve_count = 0;
        done_count = 0;
    end

    always @(posedge clk)
    begin
        cell_result_t e, got;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_WIDTH:  cols_cfg = pwdata[5:0];
                    REG_HEIGHT: rows_cfg = pwdata[5:0];
                    REG_SROW:   srow_cfg = pwdata[4:0];
                    REG_SCOL:   scol_cfg = pwdata[4:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = '{carved_row, carved_col, carved_dir, carved, finished,
                        wall_bits, bad_query};
                if (expected_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (got.row !== e.row)
                        $error("carved_row exp %0d got %0d", e.row, got.row);
                    if (got.col !== e.col)
                        $error("carved_col exp %0d got %0d", e.col, got.col);
                    if (got.dir !== e.dir)
                        $error("carved_dir exp %0d got %0d", e.dir, got.dir);
                    if (got.carved !== e.carved)
                        $error("carved exp %0d got %0d", e.carved, got.carved);
                    if (got.finished !== e.finished)
                        $error("finished exp %0d got %0d", e.finished, got.finished);
                    if (got.walls !== e.walls)
                        $error("wall_bits exp %0h got %0h", e.walls, got.walls);
                    if (got.bad !== e.bad)
                        $error("bad_query exp %0d got %0d", e.bad, got.bad);
                    if (got !== e)
                        fail_count++;
                    carve_count += e.carved;
                    done_count += e.finished;
                end
            end
            if (in_valid && in_ready)
            begin
                carve_predict(opcode, random_pick, query_row, query_col, e);
                expected_q.insert(expected_q.size(), e);
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== dv/tb_grid_maze_dfs_carver_top.sv =====
module tb_grid_maze_dfs_carver_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gmaze_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int PHASES = 10;
    localparam int PER_PHASE = 180;
    localparam int STALL_LIMIT = 6000;
    localparam int HOLD_CYCLES = 2000;

    logic               clk, rst_n;
    logic               psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata, prdata;
    logic               in_valid, in_ready, out_valid, out_ready;
    logic [1:0]         opcode, carved_dir;
    logic [7:0]         random_pick;
    logic [ROW_W-1:0]   query_row, carved_row;
    logic [COL_W-1:0]   query_col, carved_col;
    logic               carved, finished, bad_query;
    logic [3:0]         wall_bits;
    int                 fail_count, pending, carve_count, done_count;
    int                 tx_idle, rx_idle, phase_no, beats_in, quiet;
    bit                 hold_done;

    grid_maze_dfs_carver_top i_dut (.*);

    grid_maze_checker i_checker (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(negedge clk)
    begin
        if (phase_no == 4 && !hold_done && rst_n)
        begin
            out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_done = 1'b1;
        end
        out_ready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > STALL_LIMIT)
        begin
            $display("grid_maze_dfs_carver_top: mismatch");
            $finish;
        end
    end

    task automatic send(input logic [1:0] op, input logic [7:0] pick,
                        input logic [4:0] qr, input logic [4:0] qc);
        if ($urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            while ($urandom_range(99) < tx_idle)
                @(negedge clk);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        random_pick <= pick;
        query_row <= qr;
        query_col <= qc;
        while (!in_ready)
            @(negedge clk);
        @(negedge clk);
        beats_in++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    int cfg [PHASES][5] = '{
        '{32, 32, 0, 0, 1}, '{1, 1, 0, 0, 1}, '{0, 0, 5, 5, 1},
        '{2, 2, 1, 1, 1}, '{63, 63, 31, 31, 1}, '{6, 6, 0, 0, 0},
        '{4, 3, 31, 31, 1}, '{32, 1, 0, 7, 1}, '{1, 32, 20, 0, 1},
        '{5, 7, 2, 3, 1}
    };

    initial
    begin
        int sel;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        opcode = OP_START;
        random_pick = '0;
        query_row = '0;
        query_col = '0;
        out_ready = 1'b0;
        phase_no = 0;
        beats_in = 0;
        quiet = 0;
        hold_done = 1'b0;
        tx_idle = 9;
        rx_idle = 78;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        send(OP_STEP, 8'hff, 5'd0, 5'd0);
        send(OP_READ, 8'h00, 5'd0, 5'd0);
        send(OP_READ, 8'h00, 5'd31, 5'd31);
        send(OP_NOP, 8'h5a, 5'd17, 5'd9);
        send(OP_START, 8'h00, 5'd0, 5'd0);
        send(OP_READ, 8'h00, 5'd0, 5'd0);
        send(OP_STEP, 8'h00, 5'd0, 5'd0);
        send(OP_STEP, 8'hff, 5'd31, 5'd31);
        send(OP_STEP, 8'h55, 5'd0, 5'd0);
        send(OP_STEP, 8'haa, 5'd0, 5'd0);
        send(OP_STEP, 8'h03, 5'd0, 5'd0);
        send(OP_READ, 8'hff, 5'd0, 5'd1);
        send(OP_READ, 8'h00, 5'd1, 5'd0);
        send(OP_NOP, 8'h00, 5'd0, 5'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            phase_no = p;
            tx_idle = (p < 3) ? 9 : (p < 7) ? 78 : 0;
            rx_idle = (p < 3) ? 78 : (p < 7) ? 9 : 0;
            if (p != 0)
            begin
                write_reg(REG_WIDTH, cfg[p][0]);
                write_reg(REG_HEIGHT, cfg[p][1]);
                write_reg(REG_SROW, cfg[p][2]);
                write_reg(REG_SCOL, cfg[p][3]);
            end
            if (cfg[p][4] != 0)
                send(OP_START, 8'($urandom), 5'($urandom), 5'($urandom));
            for (int i = 0; i < PER_PHASE; i++)
            begin
                sel = $urandom_range(99);
                if (sel < 64)
                    send(OP_STEP, 8'($urandom), 5'($urandom), 5'($urandom));
                else if (sel < 93)
                    send(OP_READ, 8'($urandom), 5'($urandom), 5'($urandom));
                else if (sel < 98)
                    send(OP_NOP, 8'($urandom), 5'($urandom), 5'($urandom));
                else
                    send(OP_START, 8'($urandom), 5'($urandom), 5'($urandom));
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        $display("%0d items over %0d grid settings, %0d walls carved,", beats_in,
                 PHASES, carve_count);
        $display("%0d results reported a finished or empty maze", done_count);
        if (fail_count == 0)
            $display("grid_maze_dfs_carver_top: match");
        else
            $display("grid_maze_dfs_carver_top: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/gmaze_pkg.sv
hdl/grid_maze_dfs_carver_top.sv
dv/grid_maze_checker.sv
dv/tb_grid_maze_dfs_carver_top.sv
